### hdl/htw_pkg.sv
//------------------------------------------------------------------------------
// htw_pkg
// Shared types and codes for the hashed timer wheel.
//------------------------------------------------------------------------------
`default_nettype none
package htw_pkg;

	// Wheel geometry. The spoke count is a power of two so that the spoke
	// position and the rotation count come from plain bit fields.
	localparam int WHEEL_SPOKES = 4096;
	localparam int TIMER_COUNT  = 64;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  timer_index;
		logic [23:0] duration;
	} htw_in_t;

	typedef struct packed {
		logic        expired;
		logic [5:0]  expired_index;
		logic        last;
		logic [6:0]  running_count;
		logic [31:0] expiry_total;
	} htw_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DECODE,
		ST_UNLINK_RD,
		ST_UNLINK_WR,
		ST_APPEND_RD,
		ST_APPEND_WR,
		ST_TICK_RD,
		ST_WALK_RD,
		ST_WALK_EVAL,
		ST_EMIT,
		ST_DONE
	} htw_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic clear_step;
		logic unlink_rd;
		logic spoke_rd;
		logic unlink_wr;
		logic append_rd;
		logic append_wr;
		logic tick_rd;
		logic walk_rd;
		logic walk_eval;
		logic emit;
		logic done_emit;
	} htw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic op_start;
		logic op_stop;
		logic op_tick;
		logic idx_ok;
		logic cur_active;
		logic walk_nil;
		logic walk_expire;
		logic out_busy;
	} htw_sts_t;

endpackage
`default_nettype wire

### hdl/hashed_timer_wheel.sv
// Hashed timer wheel: start, stop and tick words over a pool of timers.
// A start or stop result is loaded when its word is done: an idle stop goes
// straight to the result, a fresh start appends, a running stop unlinks, and
// a restart unlinks and then appends. A tick walks the timers on the next
// spoke. A stalled result side holds any result; then the next word is taken.
// After reset the whole spoke memory is cleared before the first word is taken.
//------------------------------------------------------------------------------
// hashed_timer_wheel
// Top level joining the sequencer and the wheel datapath.
//------------------------------------------------------------------------------
`default_nettype none
module hashed_timer_wheel import htw_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire htw_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output htw_out_t     out_data
);
	htw_cmd_t cmd;
	htw_sts_t sts;

	// The sequencer walks one list element per visit to its read state.
	htw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	// The datapath holds the spoke memory, link tables and the result register.
	htw_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_data), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_data)
	);

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second word taken");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.expired |-> out_data.last) else $error("bad last");
`endif
endmodule
`default_nettype wire

### hdl/htw_datapath.sv
//------------------------------------------------------------------------------
// htw_datapath
// Spoke memories, timer link tables, counters and the output register.
//------------------------------------------------------------------------------
`default_nettype none
module htw_datapath import htw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire htw_in_t  in_word,
	input  wire htw_cmd_t cmd,
	output htw_sts_t      sts,
	output logic          out_valid,
	input  wire logic     out_ready,
	output htw_out_t      out_word
);
	localparam int SW = (WHEEL_SPOKES > 1) ? $clog2(WHEEL_SPOKES) : 1;
	localparam int TW = $clog2(TIMER_COUNT);
	localparam int LW = TW + 1;	// link width, the value TIMER_COUNT is nil
	localparam int CW = $clog2(TIMER_COUNT + 1);
	localparam logic [LW-1:0] NIL = LW'(TIMER_COUNT);

	// Head and tail share one word per spoke; memory read data is registered.
	logic [2*LW-1:0] spoke_mem [WHEEL_SPOKES];
	logic [LW-1:0]   next_mem  [TIMER_COUNT];
	logic [LW-1:0]   prev_mem  [TIMER_COUNT];
	logic [SW-1:0]   tspk_mem  [TIMER_COUNT];
	logic [11:0]     rot_mem   [TIMER_COUNT];
	logic [TIMER_COUNT-1:0] active_q;

	htw_in_t       item_q;
	logic [SW-1:0] now_q;
	logic [SW:0]   clr_q;
	logic [CW-1:0] count_q;
	logic [31:0]   total_q;
	logic          any_exp_q;

	// Working registers for the current link operation.
	logic [TW-1:0] tgt_q;	// timer being unlinked / appended / walked
	logic [LW-1:0] prv_q, nxt_q;
	logic [SW-1:0] spk_q;
	logic [11:0]   rot_q;
	logic [2*LW-1:0] hd_q;	// spoke word as read
	logic [LW-1:0] cur_q;
	logic [LW-1:0] walk_nxt_q;

	// An expired timer is held back until the walk shows whether it is the
	// final one of the tick.
	logic [TW-1:0] emit_idx_q;
	logic [CW-1:0] held_cnt_q;
	logic [31:0]   held_tot_q;

	logic [TW-1:0] idx;
	logic [SW-1:0] app_pos;
	logic [SW-1:0] tick_pos;
	assign idx = item_q.timer_index[TW-1:0];
	assign app_pos = SW'((32'(now_q) + 32'(item_q.duration) % WHEEL_SPOKES) % WHEEL_SPOKES);
	assign tick_pos = (32'(now_q) == WHEEL_SPOKES - 1) ? '0 : now_q + SW'(1);

	// Spoke memory: one read port and one write port.
	logic            sp_we;
	logic [SW-1:0]   sp_wa;
	logic [2*LW-1:0] sp_wd;
	logic [SW-1:0]   sp_ra;
	logic [2*LW-1:0] sp_rd_q;
	logic [2*LW-1:0] spoke_word;

	always_comb begin
		sp_we = 1'b0;
		sp_wa = spk_q;
		sp_wd = hd_q;
		sp_ra = spk_q;
		if (cmd.clear_step) begin
			sp_we = 1'b1;
			sp_wa = clr_q[SW-1:0];
			sp_wd = {NIL, NIL};
		end else if (cmd.unlink_wr) begin
			sp_we = 1'b1;
			sp_wd = {(prv_q == NIL) ? nxt_q : spoke_word[2*LW-1:LW],
				(nxt_q == NIL) ? prv_q : spoke_word[LW-1:0]};
		end else if (cmd.append_wr) begin
			sp_we = 1'b1;
			sp_wd = {(spoke_word[LW-1:0] == NIL) ? LW'(tgt_q) : spoke_word[2*LW-1:LW],
				LW'(tgt_q)};
		end
		if (cmd.append_rd) sp_ra = app_pos;
		if (cmd.tick_rd) sp_ra = tick_pos;
	end

	always_ff @(posedge clk) begin
		if (sp_we) spoke_mem[sp_wa] <= sp_wd;
		sp_rd_q <= spoke_mem[sp_ra];
	end

	// Timer tables. Reads are taken at the address of the timer in hand.
	logic [TW-1:0] rd_t;
	assign rd_t = cmd.walk_rd ? cur_q[TW-1:0] : idx;

	always_ff @(posedge clk) begin
		if (cmd.unlink_rd || cmd.walk_rd) begin
			tgt_q      <= rd_t;
			prv_q      <= prev_mem[rd_t];
			nxt_q      <= next_mem[rd_t];
			walk_nxt_q <= next_mem[rd_t];
			spk_q      <= tspk_mem[rd_t];
			rot_q      <= rot_mem[rd_t];
		end
		if (cmd.append_rd) begin
			tgt_q <= idx;
			spk_q <= app_pos;
		end
		if (cmd.tick_rd) spk_q <= tick_pos;
	end

	// hd_q captures the registered spoke read data, which hd_load_q flags after a read.
	logic hd_load_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hd_load_q <= 1'b0;
		else hd_load_q <= cmd.spoke_rd || cmd.walk_rd || cmd.append_rd || cmd.tick_rd;
	end

	assign spoke_word = hd_load_q ? sp_rd_q : hd_q;

	always_ff @(posedge clk) begin
		if (hd_load_q) hd_q <= sp_rd_q;
		if (cmd.tick_rd) cur_q <= NIL;
		if (cmd.walk_eval) cur_q <= walk_nxt_q;
		if (hd_load_q && cur_q == NIL && spk_q == now_q) cur_q <= sp_rd_q[2*LW-1:LW];
		if (cmd.emit) begin
			emit_idx_q <= tgt_q;
			held_cnt_q <= count_q - CW'(1);
			held_tot_q <= total_q + 32'd1;
		end
	end

	// Table writes for unlink, append and the rotation decrement.
	always_ff @(posedge clk) begin
		if (cmd.unlink_wr) begin
			if (prv_q != NIL) next_mem[prv_q[TW-1:0]] <= nxt_q;
			if (nxt_q != NIL) prev_mem[nxt_q[TW-1:0]] <= prv_q;
		end
		if (cmd.append_wr) begin
			rot_mem[tgt_q]  <= 12'(item_q.duration / WHEEL_SPOKES);
			tspk_mem[tgt_q] <= spk_q;
			prev_mem[tgt_q] <= spoke_word[LW-1:0];
			next_mem[tgt_q] <= NIL;
			if (spoke_word[LW-1:0] != NIL) next_mem[spoke_word[TW-1:0]] <= LW'(tgt_q);
		end
		if (cmd.walk_eval && rot_q != '0) rot_mem[tgt_q] <= rot_q - 12'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= in_word;
	end

	logic do_expire;
	assign do_expire = cmd.walk_eval && rot_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			now_q     <= '0;
			clr_q     <= '0;
			count_q   <= '0;
			total_q   <= '0;
			any_exp_q <= 1'b0;
			out_valid <= 1'b0;
			out_word  <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + (SW+1)'(1);
			if (cmd.tick_rd) begin
				now_q     <= tick_pos;
				any_exp_q <= 1'b0;
			end
			if (cmd.unlink_wr) begin
				active_q[tgt_q] <= 1'b0;
				count_q         <= count_q - CW'(1);
			end
			if (cmd.append_wr) begin
				active_q[tgt_q] <= 1'b1;
				count_q         <= count_q + CW'(1);
			end
			if (do_expire) begin
				total_q   <= total_q + 32'd1;
				any_exp_q <= 1'b1;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			// A new expiry releases the one held before it, which is not the last.
			if (cmd.emit && any_exp_q) begin
				out_valid                <= 1'b1;
				out_word.expired         <= 1'b1;
				out_word.expired_index   <= 6'(emit_idx_q);
				out_word.last            <= 1'b0;
				out_word.running_count   <= 7'(held_cnt_q);
				out_word.expiry_total    <= held_tot_q;
			end
			if (cmd.done_emit) begin
				out_valid <= 1'b1;
				if (item_q.op == OP_TICK && any_exp_q) begin
					out_word.expired         <= 1'b1;
					out_word.expired_index   <= 6'(emit_idx_q);
					out_word.last            <= 1'b1;
					out_word.running_count   <= 7'(held_cnt_q);
					out_word.expiry_total    <= held_tot_q;
				end else begin
					out_word.expired         <= 1'b0;
					out_word.expired_index   <= 6'd0;
					out_word.last            <= 1'b1;
					out_word.running_count   <= 7'(count_q);
					out_word.expiry_total    <= total_q;
				end
			end
		end
	end

	always_comb begin
		sts.clear_done  = (clr_q == (SW+1)'(WHEEL_SPOKES));
		sts.op_start    = item_q.op == OP_START;
		sts.op_stop     = item_q.op == OP_STOP;
		sts.op_tick     = item_q.op == OP_TICK;
		sts.idx_ok      = 32'(item_q.timer_index) < TIMER_COUNT;
		sts.cur_active  = active_q[idx];
		sts.walk_nil    = cur_q == NIL;
		sts.walk_expire = rot_q == '0;
		sts.out_busy    = out_valid && !out_ready;
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= TIMER_COUNT) else $error("count overflow");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.done_emit) |-> !(out_valid && !out_ready))
		else $error("result overwritten");
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		!do_expire |=> total_q == $past(total_q)) else $error("stray expiry count");
`endif
endmodule
`default_nettype wire

### hdl/htw_ctrl.sv
//------------------------------------------------------------------------------
// htw_ctrl
// Sequencer for clearing, start, stop and the tick walk.
//------------------------------------------------------------------------------
`default_nettype none
module htw_ctrl import htw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire htw_sts_t sts,
	output htw_cmd_t      cmd
);
	htw_state_t state_q, state_d;
	logic       append_q, append_d;	// unlink is followed by an append

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			append_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			append_q <= append_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		append_d = append_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_d = ST_IDLE;
				else cmd.clear_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.op_tick) begin
					cmd.tick_rd = 1'b1;
					state_d = ST_TICK_RD;
				end else if (sts.idx_ok && (sts.op_start || sts.op_stop)) begin
					append_d = sts.op_start;
					if (sts.cur_active) begin
						cmd.unlink_rd = 1'b1;
						state_d = ST_UNLINK_RD;
					end else if (sts.op_start) begin
						cmd.append_rd = 1'b1;
						state_d = ST_APPEND_RD;
					end else state_d = ST_DONE;
				end else state_d = ST_DONE;
			end
			ST_UNLINK_RD: begin
				// Fetch the spoke word of the timer being unlinked.
				cmd.spoke_rd = 1'b1;
				state_d = ST_UNLINK_WR;
			end
			ST_UNLINK_WR: begin
				cmd.unlink_wr = 1'b1;
				if (append_q) state_d = ST_APPEND_RD;
				else state_d = ST_DONE;
			end
			ST_APPEND_RD: begin
				cmd.append_rd = 1'b1;
				state_d = ST_APPEND_WR;
			end
			ST_APPEND_WR: begin
				cmd.append_wr = 1'b1;
				state_d = ST_DONE;
			end
			ST_TICK_RD: state_d = ST_WALK_RD;
			ST_WALK_RD: begin
				if (sts.walk_nil) state_d = ST_DONE;
				else begin
					cmd.walk_rd = 1'b1;
					state_d = ST_WALK_EVAL;
				end
			end
			ST_WALK_EVAL: begin
				if (sts.walk_expire) state_d = ST_EMIT;
				else begin
					cmd.walk_eval = 1'b1;
					state_d = ST_WALK_RD;
				end
			end
			ST_EMIT: begin
				// Unlink and report; spoke word is held from the walk read.
				if (!sts.out_busy) begin
					cmd.unlink_wr = 1'b1;
					cmd.walk_eval = 1'b1;
					cmd.emit = 1'b1;
					state_d = ST_WALK_RD;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.done_emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && cmd.done_emit)) else $error("double emit");
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.unlink_wr && cmd.append_wr)) else $error("write clash");
`endif
endmodule
`default_nettype wire
